// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Operation codes carried on the input channel
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Character codes and register reset value
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_FINISH
    } state_t;

    // Cursor update commands from the sequencer
    typedef struct packed {
        logic home;
        logic scroll;
        logic newline;
        logic advance;
    } cur_cmd_t;

endpackage

// ===== rtl/core/text_console_writer_core.sv =====
// Top level of the text console writer: attribute register, sequencer, cursor, screen RAM.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid / in_stall       | operation, character, cell_index
//  output   | out_valid / out_stall     | cursor, read_character, read_attribute
//  config   | cfg_write                 | cfg_data (text attribute)
//
//  Put character runs through the put and finish steps, read cell through the read and
//  finish steps, and an unused code goes straight to finish. A put at the end position
//  first scrolls the screen, one RAM cell per cycle through the single write port;
//  clear rewrites every cell one per cycle as well. After reset the screen RAM is zeroed
//  one cell a cycle with in_stall high; configuration writes are taken throughout.
//  The next transaction is taken while a result waits; a stalled result holds
//  the block in its finish step.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  character,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cursor,
    output logic [7:0]  read_character,
    output logic [7:0]  read_attribute,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + 1);

    logic [7:0]    attr_reg;
    cur_cmd_t      cmd;
    logic [CW-1:0] cur_lin;
    logic          at_end;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Text attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_write)
        begin
            attr_reg <= cfg_data;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .character      (character),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor         (cursor),
        .read_character (read_character),
        .read_attribute (read_attribute),
        .attr           (attr_reg),
        .cmd            (cmd),
        .cur_lin        (cur_lin),
        .at_end         (at_end),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .lin    (cur_lin),
        .at_end (at_end)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/tcw_cursor.sv =====
// Cursor tracker: linear cell index kept alongside row and column counters.
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cur_cmd_t                             cmd,
    output logic [$clog2(ROWS*COLUMNS+1)-1:0]    lin,
    output logic                                 at_end
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int CW         = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int COL_W      = $clog2(COLUMNS + 1);

    logic [CW-1:0]    lin_reg, lin_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Next cursor position; only one command is active at a time
    always_comb
    begin
        lin_next = lin_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.home)
        begin
            lin_next = '0;
            row_next = '0;
            col_next = '0;
        end
        else if (cmd.scroll)
        begin
            lin_next = lin_reg - CW'(COLUMNS);
            row_next = row_reg - 1'b1;
        end
        else if (cmd.newline)
        begin
            lin_next = lin_reg - CW'(col_reg) + CW'(COLUMNS);
            row_next = row_reg + 1'b1;
            col_next = '0;
        end
        else if (cmd.advance)
        begin
            lin_next = lin_reg + 1'b1;
            if (col_reg == COL_W'(COLUMNS - 1))
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            lin_reg <= lin_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign lin    = lin_reg;
    assign at_end = (row_reg == ROW_W'(ROWS));

    // Cursor never runs past the one-past-last cell
    a_lin_range: assert property (@(posedge clk) disable iff (!rst_n)
        lin_reg <= CW'(CELL_COUNT))
        else $error("cursor beyond end of screen");

    // Row/column view agrees with the linear index at the end position
    a_end_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        at_end |-> (col_reg == '0 && lin_reg == CW'(CELL_COUNT)))
        else $error("row/column out of step with linear cursor");

    // Scroll only pulls the cursor back from the end position
    a_scroll_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scroll |-> at_end)
        else $error("scroll with cursor inside screen");

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Sequencer: sweeps the screen RAM for init, scroll and clear; runs put/read; holds results.
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              operation,
    input  logic [7:0]                              character,
    input  logic [10:0]                             cell_index,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [10:0]                             cursor,
    output logic [7:0]                              read_character,
    output logic [7:0]                              read_attribute,
    // attribute register
    input  logic [7:0]                              attr,
    // cursor tracker
    output cur_cmd_t                                cmd,
    input  logic [$clog2(ROWS*COLUMNS+1)-1:0]       cur_lin,
    input  logic                                    at_end,
    // screen RAM
    output logic                                    ram_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]         ram_waddr,
    output logic [15:0]                             ram_wdata,
    output logic                                    ram_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0]         ram_raddr,
    input  logic [15:0]                             ram_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELL_COUNT - COLUMNS);

    state_t state_reg, state_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] wr_addr_reg;

    logic [1:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [10:0]   idx_reg;

    logic          out_valid_reg, out_valid_next;
    logic [10:0]   cursor_reg;
    logic [7:0]    rd_ch_reg;
    logic [7:0]    rd_at_reg;

    logic          accept;
    logic          out_free;
    logic          load_out;
    logic          idx_in_range;
    logic [31:0]   cur_wide;
    logic          addr_last;

    assign in_stall     = (state_reg != ST_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign load_out     = (state_reg == ST_FINISH) && out_free;
    assign idx_in_range = (32'(idx_reg) < 32'(CELL_COUNT));
    assign cur_wide     = 32'(cur_lin);
    assign addr_last    = (addr_reg == LAST_ADDR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_PUT:   state_next = at_end ? ST_COPY : ST_PUT;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_COPY:
            begin
                if (addr_reg == SCROLL_END)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (addr_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_CLEAR:
            begin
                if (addr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUT:    state_next = ST_FINISH;
            ST_READ:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM port and cursor command decode
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {attr, SPACE_CHAR};
        ram_re    = 1'b0;
        ram_raddr = addr_reg + AW'(COLUMNS);
        cmd       = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_COPY:
            begin
                // read one row ahead, write the previous read one row up
                ram_re    = (addr_reg != SCROLL_END);
                ram_we    = pend_reg;
                ram_waddr = wr_addr_reg;
                ram_wdata = ram_rdata;
            end
            ST_FILL:
            begin
                ram_we     = 1'b1;
                cmd.scroll = addr_last;
            end
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cmd.home = addr_last;
            end
            ST_PUT:
            begin
                if (ch_reg == NEWLINE_CHAR)
                begin
                    cmd.newline = 1'b1;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = AW'(cur_lin);
                    ram_wdata   = {attr, ch_reg};
                    cmd.advance = 1'b1;
                end
            end
            ST_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sweep address counter and copy pipeline stage
    always_comb
    begin
        addr_next = addr_reg;
        pend_next = 1'b0;
        unique case (state_reg) inside
            ST_INIT, ST_FILL, ST_CLEAR:
            begin
                addr_next = addr_last ? '0 : addr_reg + 1'b1;
            end
            ST_COPY:
            begin
                pend_next = ram_re;
                if (ram_re)
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= addr_reg;
        if (accept)
        begin
            op_reg  <= operation;
            ch_reg  <= character;
            idx_reg <= cell_index;
        end
        if (load_out)
        begin
            cursor_reg <= cur_wide[10:0];
            if (op_reg == OP_READ && idx_in_range)
            begin
                rd_ch_reg <= ram_rdata[7:0];
                rd_at_reg <= ram_rdata[15:8];
            end
            else
            begin
                rd_ch_reg <= '0;
                rd_at_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor         = cursor_reg;
    assign read_character = rd_ch_reg;
    assign read_attribute = rd_at_reg;

    // Once an item is taken the block is busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken twice in a row");

    // A result appears only out of the finish state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result without finished transaction");

    // At most one cursor update per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.home, cmd.scroll, cmd.newline, cmd.advance}))
        else $error("conflicting cursor commands");

    // Copy writes always land one row above the read just issued
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && ram_re) |=>
            (pend_reg && wr_addr_reg + AW'(COLUMNS) == $past(ram_raddr)))
        else $error("scroll copy out of order");

endmodule
